// ===== src/lru_recency_list_assert.svh =====
// ---------------------------------------------------------------------------
// LRU recency list assertion macros
// Shorthand for concurrent checks clocked on clk_i, with or without reset.
// ---------------------------------------------------------------------------
`ifndef LRU_RECENCY_LIST_ASSERT_SVH
`define LRU_RECENCY_LIST_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check that is ignored while rst_ni is low.
`define LRL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("lru_recency_list assertion failed");
// Check that also holds during reset.
`define LRL_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("lru_recency_list assertion failed");
`else
`define LRL_ASSERT(lbl, prop)
`define LRL_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== src/lrl_pkg.sv =====
// ---------------------------------------------------------------------------
// LRU recency list package
// Sizes, operation and register codes, and the structs passed between cells.
// ---------------------------------------------------------------------------
package lrl_pkg;

  localparam int DEPTH     = 8;
  localparam int ITEM_BITS = 16;
  localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);

  // Widths fixed by the register and result fields.
  localparam int CAP_W    = 4;
  localparam int POS_W    = 3;
  localparam int OUTCNT_W = 4;

  localparam logic OP_REF   = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // Register index of the capacity register.
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(8);

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic             ref_en;  // accepted reference this cycle
    logic             hit;     // the item is held somewhere in the list
    logic [CNT_W-1:0] n_lim;   // on a miss, ranks 1..n_lim shift back
    logic [CNT_W-1:0] occ;     // current occupancy
  } cell_ctrl_t;

  // Data rippling from rank 0 toward the least recent rank.
  typedef struct packed {
    logic                 found;    // a match exists at a lower rank
    logic [ITEM_BITS-1:0] ev_data;  // entry at rank occ-1, zero elsewhere
  } cell_chain_t;

endpackage

// ===== src/lrl_cell.sv =====
// ---------------------------------------------------------------------------
// LRU recency list cell
// Holds the entry of one rank, compares it and takes its neighbor's entry.
// ---------------------------------------------------------------------------
module lrl_cell (
  input  logic                         clk_i,
  input  logic [lrl_pkg::IDX_W-1:0]     idx_i,
  input  logic [lrl_pkg::ITEM_BITS-1:0] item_i,
  input  logic [lrl_pkg::ITEM_BITS-1:0] prev_i,
  input  lrl_pkg::cell_ctrl_t           ctrl_i,
  input  lrl_pkg::cell_chain_t          chain_i,
  output lrl_pkg::cell_chain_t          chain_o,
  output logic [lrl_pkg::ITEM_BITS-1:0] entry_o,
  output logic                          first_o
);
  import lrl_pkg::*;

  logic [ITEM_BITS-1:0] entry_q;
  logic [CNT_W-1:0]     rank;
  logic                 in_use;
  logic                 match;
  logic                 is_last;
  logic                 load;

  assign rank    = CNT_W'(idx_i);
  assign in_use  = rank < ctrl_i.occ;
  assign match   = in_use && (entry_q == item_i);
  assign is_last = (rank + CNT_W'(1)) == ctrl_i.occ;

  assign first_o         = match && !chain_i.found;
  assign chain_o.found   = chain_i.found || match;
  assign chain_o.ev_data = chain_i.ev_data | (is_last ? entry_q : '0);
  assign entry_o         = entry_q;

  // On a hit every rank up to the hit one shifts; on a miss ranks up to n_lim.
  assign load = ctrl_i.ref_en &&
                (ctrl_i.hit ? !chain_i.found : (rank <= ctrl_i.n_lim));

  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_q <= prev_i;
    end
  end

endmodule

// ===== src/lru_recency_list.sv =====
// ---------------------------------------------------------------------------
// LRU recency list
// Move-to-front list of item identifiers with least recent eviction.
// ---------------------------------------------------------------------------
// Each input word is one operation: tuser selects a reference (0) or a clear
// (1) and tdata carries the 16-bit item. One result word follows every
// operation. The list is a row of DEPTH cells, one per recency rank; all
// cells compare their entry with the item in the same cycle, and the first
// match ripples down the row; the result is registered as the word is taken,
// and a new word is taken every cycle while the result register is free
// or being drained. The capacity register (byte address 0) limits how many
// ranks are in use; zero acts as one and values above DEPTH act as DEPTH.
// Clear empties the list but keeps the capacity. Entries need no reset
// since only ranks below the occupancy count are ever looked at.
`include "lru_recency_list_assert.svh"

module lru_recency_list (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Operation input.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] item_value
  input  logic        s_axis_tuser,   // [0] operation
  // Result output.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [0] hit, [3:1] hit_position, [4] evicted,
                                      // [20:5] evicted_item, [24:21] entry_count
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lrl_pkg::*;

  // Configuration register.
  logic [CAP_W-1:0] cap_q;
  logic             cfg_sel;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[2] == REG_CAPACITY);
  assign prdata  = cfg_sel ? 32'(cap_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  // Handshake: a word is taken whenever the result register can accept one.
  logic s_accept;
  logic out_valid_q;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Capacity clamp and insert limit.
  logic [CNT_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] eff_cap;
  logic [CNT_W-1:0] n_lim;
  logic             full;

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if ({1'b0, cap_q} > (CAP_W + 1)'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_q);
    end
  end

  assign full  = occ_q >= eff_cap;
  assign n_lim = full ? (eff_cap - CNT_W'(1)) : occ_q;

  // Cell row.
  logic [ITEM_BITS-1:0] item;
  logic                 is_clear;
  cell_ctrl_t           ctrl;
  cell_chain_t          chain  [DEPTH+1];
  logic [ITEM_BITS-1:0] entries[DEPTH];
  logic [DEPTH-1:0]     first;
  logic                 hit;

  assign item     = s_axis_tdata[ITEM_BITS-1:0];
  assign is_clear = (s_axis_tuser == OP_CLEAR);
  assign hit      = chain[DEPTH].found;

  assign chain[0].found   = 1'b0;
  assign chain[0].ev_data = '0;

  assign ctrl.ref_en = s_accept && !is_clear;
  assign ctrl.hit    = hit;
  assign ctrl.n_lim  = n_lim;
  assign ctrl.occ    = occ_q;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ITEM_BITS-1:0] prev;
    if (g == 0) begin : g_head
      assign prev = item;
    end else begin : g_body
      assign prev = entries[g-1];
    end

    lrl_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(g)),
      .item_i  (item),
      .prev_i  (prev),
      .ctrl_i  (ctrl),
      .chain_i (chain[g]),
      .chain_o (chain[g+1]),
      .entry_o (entries[g]),
      .first_o (first[g])
    );
  end

  // Rank of the first match; at most one bit of first is set.
  logic [IDX_W-1:0] pos;

  always_comb begin
    pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (first[i]) begin
        pos = pos | IDX_W'(i);
      end
    end
  end

  // Occupancy update.
  always_comb begin
    occ_d = occ_q;
    if (s_accept) begin
      if (is_clear) begin
        occ_d = '0;
      end else if (!hit) begin
        occ_d = n_lim + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (s_accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  logic                 out_hit_q;
  logic [POS_W-1:0]     out_pos_q;
  logic                 out_ev_q;
  logic [ITEM_BITS-1:0] out_ev_item_q;
  logic [OUTCNT_W-1:0]  out_cnt_q;
  logic                 miss_evict;

  assign miss_evict = !is_clear && !hit && full;

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      out_hit_q     <= !is_clear && hit;
      out_pos_q     <= is_clear ? '0 : POS_W'(pos);
      out_ev_q      <= miss_evict;
      out_ev_item_q <= miss_evict ? chain[DEPTH].ev_data : '0;
      out_cnt_q     <= OUTCNT_W'(occ_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_cnt_q, out_ev_item_q, out_ev_q, out_pos_q, out_hit_q};

  // Checks.
  `LRL_ASSERT(a_occ_bound, occ_q <= CNT_W'(DEPTH))
  `LRL_ASSERT(a_evict_not_hit, m_axis_tvalid && out_ev_q |-> !out_hit_q)
  `LRL_ASSERT(a_clear_empties, s_accept && is_clear |=> occ_q == '0)
  `LRL_ASSERT(a_hit_keeps_count, ctrl.ref_en && hit |=> occ_q == $past(occ_q))

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// LRU recency list testbench
// Drives reference and clear words through the stream input under random
// bursts, drains results under a shifting stall pattern, moves the capacity
// register through its extremes over APB, and checks every result word
// field by field against a move-to-front list kept inside the bench.
// ---------------------------------------------------------------------------
module tb;
  import lrl_pkg::*;

  // Result word as laid out on m_axis_tdata, lowest bit last in the list.
  typedef struct packed {
    logic [6:0]           pad;
    logic [OUTCNT_W-1:0]  count;
    logic [ITEM_BITS-1:0] evicted_item;
    logic                 evicted;
    logic [POS_W-1:0]     position;
    logic                 hit;
  } lru_result_t;

  // How the result side takes words during one stretch of the run.
  typedef enum int unsigned {
    SINK_OPEN,     // always ready
    SINK_RANDOM,   // coin flip each cycle
    SINK_SPARSE,   // one cycle in four
    SINK_BLOCKED   // long stalls with short openings
  } sink_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] item_value
  logic        s_axis_tuser = 1'b0; // [0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [0] hit, [3:1] hit_position, [4] evicted,
                                    // [20:5] evicted_item, [24:21] entry_count
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lru_recency_list DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Generous ceiling on the run time, far above the slowest legal run.
  initial begin
    #2_000_000;
    $display("lru_recency_list test failed");
    $finish;
  end

  // -------------------------------------------------------------------------
  // Shadow of the list: held identifiers by rank, how many are held, and
  // the capacity register as last written.
  // -------------------------------------------------------------------------
  logic [ITEM_BITS-1:0] held_items [DEPTH];
  int unsigned          held_count = 0;
  logic [CAP_W-1:0]     capacity_reg = CAP_RESET;

  lru_result_t expected_results [$];

  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned hits_seen = 0;
  int unsigned evictions_seen = 0;
  int unsigned clears_seen = 0;
  int unsigned capacity_writes = 0;

  // Applies one operation to the shadow list and returns the word the block
  // should answer with.
  function automatic lru_result_t apply_operation(input logic op,
                                                  input logic [ITEM_BITS-1:0] item);
    lru_result_t r;
    int          rank;
    int          keep;
    int          cap;
    r    = '0;
    rank = -1;
    if (op == OP_CLEAR) begin
      held_count = 0;
    end else begin
      for (int i = 0; i < held_count; i++) begin
        if (rank < 0 && held_items[i] == item) rank = i;
      end
      if (rank >= 0) begin
        // Hit: everything above the found rank slides back by one.
        for (int i = rank; i > 0; i--) held_items[i] = held_items[i-1];
        held_items[0] = item;
        r.hit      = 1'b1;
        r.position = POS_W'(rank);
      end else begin
        // Zero capacity behaves as one, anything above DEPTH as DEPTH.
        cap = (capacity_reg == 0) ? 1 : (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
        if (held_count >= cap) begin
          // When capacity was lowered under the fill level, the least recent
          // held entry is the one reported and the list is cut to capacity.
          r.evicted      = 1'b1;
          r.evicted_item = held_items[held_count-1];
          keep           = cap - 1;
        end else begin
          keep = held_count;
        end
        for (int i = keep; i > 0; i--) held_items[i] = held_items[i-1];
        held_items[0] = item;
        held_count    = keep + 1;
      end
    end
    r.count = OUTCNT_W'(held_count);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Every accepted operation is predicted at its handshake edge; every
  // accepted result word is compared with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    lru_result_t want;
    lru_result_t got;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(apply_operation(s_axis_tuser, s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_results.size() == 0) begin
          $error("result word 0x%08h arrived with nothing outstanding", m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("hit", 32'(want.hit), 32'(got.hit));
          check_field("hit_position", 32'(want.position), 32'(got.position));
          check_field("evicted", 32'(want.evicted), 32'(got.evicted));
          check_field("evicted_item", 32'(want.evicted_item), 32'(got.evicted_item));
          check_field("entry_count", 32'(want.count), 32'(got.count));
          check_field("padding", 32'(want.pad), 32'(got.pad));
          words_checked++;
          if (want.hit) hits_seen++;
          if (want.evicted) evictions_seen++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Result side: the ready pattern is redrawn after a random stretch, so
  // stalls land on every phase of the input traffic.
  // -------------------------------------------------------------------------
  sink_mode_e  sink_mode = SINK_OPEN;
  int unsigned sink_left = 0;
  int unsigned sink_tick = 0;

  always @(posedge clk_i) begin : sink_pattern
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_left = $urandom_range(32, 200);
    end
    sink_left--;
    sink_tick++;
    case (sink_mode)
      SINK_OPEN:   m_axis_tready <= 1'b1;
      SINK_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
      SINK_SPARSE: m_axis_tready <= (sink_tick % 4 == 0);
      default:     m_axis_tready <= ((sink_tick % 16) < 3);
    endcase
  end

  // -------------------------------------------------------------------------
  // Input side.
  // -------------------------------------------------------------------------
  int unsigned burst_left = 0;
  bit          steady_sender = 1'b0;  // no gaps at all while set

  // Sends one word. Between bursts the valid drops for a random gap; within
  // a burst it stays high from word to word.
  task automatic send_word(input logic op, input logic [ITEM_BITS-1:0] item);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = steady_sender ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= item;
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (op == OP_CLEAR) clears_seen++;
  endtask

  // Stops sending and waits until every outstanding result has been taken,
  // then idles so the result register settles.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (expected_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // One APB transfer: setup cycle, then access until pready.
  task automatic apb_transfer(input logic write, input logic [2:0] addr,
                              input logic [31:0] wdata, output logic [31:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata   = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Capacity changes only with the block idle; the written value is read
  // back to confirm the register holds it.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    logic [31:0] rdata;
    drain_results();
    apb_transfer(1'b1, 3'(4 * REG_CAPACITY), 32'(value), rdata);
    capacity_reg = value;
    capacity_writes++;
    apb_transfer(1'b0, 3'(4 * REG_CAPACITY), '0, rdata);
    check_field("capacity", 32'(value), rdata);
  endtask

  // -------------------------------------------------------------------------
  // Tests.
  // -------------------------------------------------------------------------

  // The capacity register must come out of reset at DEPTH.
  task automatic test_reset_capacity();
    logic [31:0] rdata;
    apb_transfer(1'b0, 3'(4 * REG_CAPACITY), '0, rdata);
    check_field("capacity", 32'(CAP_RESET), rdata);
  endtask

  // Extreme identifiers, hits at the front and one rank down, filling the
  // list, a full-list eviction and a hit on the least recent rank.
  task automatic test_fill_and_evict();
    steady_sender = 1'b1;
    send_word(OP_REF, 16'h0000);
    send_word(OP_REF, 16'hFFFF);
    send_word(OP_REF, 16'hFFFF);
    send_word(OP_REF, 16'h0000);
    send_word(OP_REF, 16'hAAAA);
    send_word(OP_REF, 16'h5555);
    send_word(OP_REF, 16'h0F0F);
    send_word(OP_REF, 16'hF0F0);
    send_word(OP_REF, 16'h8001);
    send_word(OP_REF, 16'h7FFE);
    send_word(OP_REF, 16'h1234);  // list full: drops the least recent
    send_word(OP_REF, 16'h0000);  // now at the least recent rank
  endtask

  // Capacity lowered below the fill level: deep entries still hit, and the
  // next miss cuts the list back. Then clears, one on an empty list, and a
  // zero capacity that must behave as one.
  task automatic test_capacity_shrink_and_clear();
    write_capacity(4'd3);
    send_word(OP_REF, 16'h5555);    // held at rank six
    send_word(OP_REF, 16'hC3C3);    // miss with eight held, capacity three
    send_word(OP_CLEAR, 16'hFFFF);  // item is ignored by a clear
    send_word(OP_CLEAR, 16'h0000);  // clear of an empty list
    write_capacity(4'd0);
    send_word(OP_REF, 16'h0001);
    send_word(OP_REF, 16'h8000);    // evicts the only entry
    send_word(OP_REF, 16'h8000);
  endtask

  // Phases of random traffic, each under its own capacity. The list is not
  // cleared between phases, so a lower capacity often meets a fuller list.
  // Most references come from a small pool of 2 to DEPTH+4 identifiers, so
  // hits, deep hits and evictions all happen often.
  task automatic test_random_traffic();
    logic [CAP_W-1:0]     cap_sweep [10] = '{4'd8, 4'd1, 4'd15, 4'd5, 4'd0,
                                             4'd3, 4'd2, 4'd8, 4'd7, 4'd12};
    logic [ITEM_BITS-1:0] pool [$];
    int unsigned          pool_size;
    int unsigned          roll;
    for (int p = 0; p < 10; p++) begin
      write_capacity(cap_sweep[p]);
      steady_sender = (p % 3 == 2);
      pool.delete();
      pool_size = $urandom_range(2, DEPTH + 4);
      for (int k = 0; k < pool_size; k++) pool.push_back(ITEM_BITS'($urandom));
      for (int n = 0; n < 200; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3)
          send_word(OP_CLEAR, ITEM_BITS'($urandom));
        else if (roll < 80)
          send_word(OP_REF, pool[$urandom_range(0, pool_size - 1)]);
        else if (roll < 95)
          send_word(OP_REF, ITEM_BITS'($urandom));
        else
          send_word(OP_REF, $urandom_range(0, 1) ? {ITEM_BITS{1'b1}} : '0);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) held_items[i] = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_capacity();
    test_fill_and_evict();
    test_capacity_shrink_and_clear();
    test_random_traffic();

    drain_results();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d words (%0d clears) under %0d capacity writes.",
             words_sent, clears_seen, capacity_writes);
    $display("Checked %0d results: %0d hits, %0d evictions, %0d mismatches.",
             words_checked, hits_seen, evictions_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("lru_recency_list test passed");
    end else begin
      $display("lru_recency_list test failed");
    end
    $finish;
  end

endmodule
